// ----- rtl/tgarle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tgarle_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_COMPRESSED   = 2'd0;
  localparam logic [1:0] REG_PIXEL_DEPTH  = 2'd1;
  localparam logic [1:0] REG_ELEMS_PER_ROW = 2'd2;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd3;

  // Pixel depth codes; codes above DEPTH_32BIT decode as 8-bit
  localparam logic [2:0] DEPTH_1BIT  = 3'd0;
  localparam logic [2:0] DEPTH_8BIT  = 3'd1;
  localparam logic [2:0] DEPTH_16BIT = 3'd2;
  localparam logic [2:0] DEPTH_24BIT = 3'd3;
  localparam logic [2:0] DEPTH_32BIT = 3'd4;

  localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
  localparam logic [7:0] HDR_LEN_MASK   = 8'h7f;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef struct packed {
    logic        compressed;
    logic [2:0]  pixel_depth;
    logic [31:0] total;
  } cfg_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/tgarle_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgarle_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [1:0]        wr_index,
  input  wire logic [15:0]       wr_data,
  output tgarle_pkg::cfg_t       cfg,
  output logic                   total_stale
);
  import tgarle_pkg::*;

  logic        compressed_r;
  logic [2:0]  pixel_depth_r;
  logic [15:0] epr_r;
  logic [15:0] rows_r;
  logic [31:0] total_r;
  logic        stale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_r  <= 1'b1;
      pixel_depth_r <= DEPTH_8BIT;
      epr_r         <= 16'd1;
      rows_r        <= 16'd1;
      stale_r       <= 1'b1;
    end else begin
      stale_r <= wr_en;
      if (wr_en) begin
        case (wr_index)
          REG_COMPRESSED:    compressed_r  <= wr_data[0];
          REG_PIXEL_DEPTH:   pixel_depth_r <= wr_data[2:0];
          REG_ELEMS_PER_ROW: epr_r         <= wr_data;
          REG_ROW_COUNT:     rows_r        <= wr_data;
          default: ;
        endcase
      end
    end
  end

  // Element total, refreshed every cycle from the size registers
  always_ff @(posedge clk) begin
    total_r <= epr_r * rows_r;
  end

  assign cfg.compressed  = compressed_r;
  assign cfg.pixel_depth = pixel_depth_r;
  assign cfg.total       = total_r;
  assign total_stale     = stale_r;

endmodule

`default_nettype wire

// ----- rtl/tgarle_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgarle_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [7:0]        data_byte,
  input  wire logic              frame_start,
  input  tgarle_pkg::cfg_t       cfg,
  output logic                   emit,
  output tgarle_pkg::result_t    res
);
  import tgarle_pkg::*;

  phase_t      phase_r, phase_nxt, phase_c;
  logic [7:0]  left_r, left_nxt, left_c;
  logic [1:0]  bip_r, bip_nxt, bip_c;
  logic [23:0] gather_r, gather_nxt, gather_c, gather_add;
  logic [31:0] emitted_r, emitted_nxt, emitted_c;
  logic        finished_r, finished_nxt, finished_c;

  logic [32:0] diff;
  logic        exhausted;
  logic [2:0]  bpp;
  logic [23:0] value;
  logic [7:0]  count, count_clip;
  logic        count_fits;

  // Apply frame_start clear before the byte is decoded
  always_comb begin
    if (frame_start) begin
      phase_c    = PH_HEADER;
      left_c     = 8'd0;
      bip_c      = 2'd0;
      gather_c   = 24'd0;
      emitted_c  = 32'd0;
      finished_c = 1'b0;
    end else begin
      phase_c    = phase_r;
      left_c     = left_r;
      bip_c      = bip_r;
      gather_c   = gather_r;
      emitted_c  = emitted_r;
      finished_c = finished_r;
    end
  end

  assign diff      = {1'b0, cfg.total} - {1'b0, emitted_c};
  assign exhausted = diff[32] || (diff[31:0] == 32'd0);

  always_comb begin
    case (cfg.pixel_depth)
      DEPTH_16BIT: bpp = 3'd2;
      DEPTH_24BIT: bpp = 3'd3;
      DEPTH_32BIT: bpp = 3'd4;
      default:     bpp = 3'd1;
    endcase
  end

  always_comb begin
    case (bip_c)
      2'd0:    gather_add = gather_c | {16'd0, data_byte};
      2'd1:    gather_add = gather_c | {8'd0, data_byte, 8'd0};
      2'd2:    gather_add = gather_c | {data_byte, 16'd0};
      default: gather_add = gather_c;
    endcase
  end

  always_comb begin
    case (cfg.pixel_depth)
      DEPTH_1BIT:  value = {16'd0, ~gather_add[7:0]};
      DEPTH_16BIT: value = {8'd0, gather_add[14:5], 1'b0, gather_add[4:0]};
      DEPTH_24BIT, DEPTH_32BIT: value = gather_add;
      default:     value = {16'd0, gather_add[7:0]};
    endcase
  end

  always_comb begin
    phase_nxt    = phase_c;
    left_nxt     = left_c;
    bip_nxt      = bip_c;
    gather_nxt   = gather_c;
    emitted_nxt  = emitted_c;
    finished_nxt = finished_c;
    emit         = 1'b0;
    count        = 8'd1;
    count_clip   = 8'd1;
    count_fits   = 1'b1;
    if (finished_c) begin
      emit = 1'b0;
    end else if (exhausted) begin
      finished_nxt = 1'b1;
    end else if (cfg.compressed && phase_c != PH_REPEAT && phase_c != PH_LITERAL) begin
      // Packet header: kind and length
      phase_nxt  = ((data_byte & HDR_REPEAT_BIT) != 8'd0) ? PH_REPEAT : PH_LITERAL;
      left_nxt   = (data_byte & HDR_LEN_MASK) + 8'd1;
      bip_nxt    = 2'd0;
      gather_nxt = 24'd0;
    end else if ({1'b0, bip_c} + 3'd1 < bpp) begin
      bip_nxt    = bip_c + 2'd1;
      gather_nxt = gather_add;
    end else begin
      bip_nxt    = 2'd0;
      gather_nxt = 24'd0;
      if (cfg.compressed) begin
        if (phase_c == PH_REPEAT) begin
          count     = left_c;
          left_nxt  = 8'd0;
          phase_nxt = PH_HEADER;
        end else begin
          left_nxt = left_c - 8'd1;
          if (left_nxt == 8'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
        if (count == 8'd0) begin
          count = 8'd1;
        end
      end
      // Clip to what remains of the image
      count_fits = (diff[31:8] != 24'd0) || (count < diff[7:0]);
      count_clip = count_fits ? count : diff[7:0];
      emitted_nxt  = emitted_c + {24'd0, count_clip};
      finished_nxt = !count_fits;
      emit         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      left_r     <= 8'd0;
      bip_r      <= 2'd0;
      gather_r   <= 24'd0;
      emitted_r  <= 32'd0;
      finished_r <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      bip_r      <= bip_nxt;
      gather_r   <= gather_nxt;
      emitted_r  <= emitted_nxt;
      finished_r <= finished_nxt;
    end
  end

  assign res.pixel_value  = value;
  assign res.repeat_count = count_clip;
  assign res.image_done   = finished_nxt;

endmodule

`default_nettype wire

// ----- rtl/tga_rle_pixel_decoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// TGA pixel-data decoder, raw or run-length encoded, one byte per transfer.
//
// Input channel (in_*): one pixel-data byte per transfer; in_frame_start marks
// the first byte of an image and clears all decode state before that byte.
// Result channel (out_*): a decoded pixel with its repeat count and a flag on
// the result that completes the image. Header bytes, partial pixel bytes and
// bytes past the end of the image give no result; alpha never enters the value.
// Configuration (cfg_*): write while idle; cfg_ready is always high. After a
// write the input stalls while the element total (a registered 16x16 product
// of the size registers) settles.
// Path: a transferred byte is held in the input register, then decoded into
// the result register once the result slot is free. Throughput: one byte per
// cycle while in_stall is low, set by the single decode stage between them.
// Stall: a held result stays on out_* ; the input register still takes one
// more byte, then in_stall rises until the result is transferred.
// Reset (rst_n low, synchronous): registers return to compressed 8-bit,
// 1x1 image, decoder waiting for a packet header, no result pending.

module tga_rle_pixel_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_pixel_value,
  output logic [7:0]       out_repeat_count,
  output logic             out_image_done,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import tgarle_pkg::*;

  cfg_t    cfg;
  logic    total_stale;
  result_t res;
  logic    emit;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_fs_r;

  // Result register
  logic        out_valid_r;
  logic [23:0] out_pixel_r;
  logic [7:0]  out_count_r;
  logic        out_done_r;

  logic out_free;
  logic advance;
  logic in_xfer;

  assign cfg_ready = 1'b1;

  tgarle_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (cfg_valid && cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .cfg         (cfg),
    .total_stale (total_stale)
  );

  // Decode may run when the result slot is empty or is being drained
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = (s1_valid_r && !out_free) || total_stale;
  assign in_xfer  = in_valid && !in_stall;

  tgarle_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (advance),
    .data_byte   (s1_byte_r),
    .frame_start (s1_fs_r),
    .cfg         (cfg),
    .emit        (emit),
    .res         (res)
  );

  // Hold the byte until the decode stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_fs_r   <= in_frame_start;
    end
  end

  // Load a new result, or drop the old one once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_pixel_r <= res.pixel_value;
      out_count_r <= res.repeat_count;
      out_done_r  <= res.image_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pixel_r;
  assign out_repeat_count = out_count_r;
  assign out_image_done   = out_done_r;

endmodule

`default_nettype wire
